### hdl/dnsd_pkg.sv
// Package for the DNS name decompressor: store sizes, field widths,
// function codes, register map and the transaction payload structs.
// No dependencies.
`default_nettype none

package dnsd_pkg;

   localparam int MSG_DEPTH  = 512;
   localparam int NAME_DEPTH = 256;
   localparam int MAX_JUMPS  = 20;

   localparam int MSG_AW  = $clog2(MSG_DEPTH);
   localparam int NAME_AW = $clog2(NAME_DEPTH);
   localparam int POS_W   = 14;
   localparam int LEN_W   = 10;
   localparam int CNT_W   = 9;
   localparam int JUMP_W  = $clog2(MAX_JUMPS + 1);
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [LEN_W-1:0]  MSG_DEPTH_LEN  = LEN_W'(MSG_DEPTH);
   localparam logic [CNT_W-1:0]  NAME_DEPTH_CNT = CNT_W'(NAME_DEPTH);
   localparam logic [JUMP_W-1:0] MAX_JUMPS_CNT  = JUMP_W'(MAX_JUMPS);
   localparam logic [CNT_W-1:0]  NAME_LIMIT_RST = 9'd256;

   localparam logic [1:0] PTR_MARK = 2'b11;
   localparam logic [7:0] DOT_CHAR = 8'h2e;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_PARSE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [CSR_AW-3:0] CSR_NAME_LIMIT = '0;

   typedef struct packed {
      logic [1:0] func;
      logic [8:0] msg_addr;
      logic [7:0] msg_byte;
      logic [8:0] start_offset;
      logic [9:0] msg_length;
      logic [7:0] name_index;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [9:0] next_offset;
      logic [8:0] name_length;
      logic [7:0] name_char;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/dns_name_decompressor_top.sv
// Top level of the DNS name decompressor: handshake, register port,
// walk sequencer and the two stores. Uses dnsd_pkg and dnsd_ram.
`default_nettype none

// A write passes through ST_DONE and a name store read through ST_NREAD and
// ST_DONE to a valid result, with one transaction in flight at a time. A parse
// walks the message through the single message store read port: ST_FETCH and
// ST_DECODE per label header, ST_COPY per stored label character and once more
// to leave the label, ST_FETCH, ST_DECODE and ST_PTRLO per compression pointer,
// ST_FETCH and ST_DECODE for the terminating zero byte (ST_FETCH alone when
// the walk reaches the message length) and ST_DONE for result hand-off.
// Label characters past the name limit are skipped in a single jump. A result
// waits in an output register while the next transaction is accepted.
module dns_name_decompressor_top import dnsd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire req_type           req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      rsp_type           rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output      logic [CSR_DW-1:0] prdata,
   output      logic              pready
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_NREAD  = 7'b0000010,
      ST_FETCH  = 7'b0000100,
      ST_DECODE = 7'b0001000,
      ST_PTRLO  = 7'b0010000,
      ST_COPY   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   mlen_ff, mlen_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   resume_ff, resume_in;
   logic               took_ff, took_in;
   logic [JUMP_W-1:0]  jumps_ff, jumps_in;
   logic [7:0]         lab_ff, lab_in;
   logic [5:0]         hi_ff, hi_in;
   logic               wpend_ff, wpend_in;
   logic [NAME_AW-1:0] waddr_ff, waddr_in;
   logic               idx_ok_ff, idx_ok_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]   name_limit_ff, name_limit_in;

   logic               msg_we;
   logic [MSG_AW-1:0]  msg_raddr;
   logic [7:0]         msg_rdata;
   logic               nm_we;
   logic [NAME_AW-1:0] nm_waddr;
   logic [7:0]         nm_wdata;
   logic [7:0]         nm_rdata;

   logic               csr_wr;
   logic [POS_W:0]     pos_inc1;
   logic [POS_W:0]     lab_end;
   logic [LEN_W-1:0]   ok_offset;
   logic [LEN_W-1:0]   ok_offset_zero;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   assign csr_wr = psel && penable && pwrite && (paddr[CSR_AW-1:2] == CSR_NAME_LIMIT);
   assign prdata = (paddr[CSR_AW-1:2] == CSR_NAME_LIMIT) ?
                   CSR_DW'(name_limit_ff) : '0;
   assign name_limit_in = csr_wr ? pwdata[CNT_W-1:0] : name_limit_ff;

   assign pos_inc1       = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign lab_end        = pos_inc1 + (POS_W+1)'(msg_rdata);
   assign ok_offset      = took_ff ? resume_ff : pos_ff[LEN_W-1:0];
   assign ok_offset_zero = took_ff ? resume_ff : pos_inc1[LEN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      mlen_in      = mlen_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      resume_in    = resume_ff;
      took_in      = took_ff;
      jumps_in     = jumps_ff;
      lab_in       = lab_ff;
      hi_in        = hi_ff;
      wpend_in     = 1'b0;
      waddr_in     = waddr_ff;
      idx_ok_in    = idx_ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      msg_we       = 1'b0;
      msg_raddr    = pos_ff[MSG_AW-1:0];
      nm_we        = wpend_ff;
      nm_waddr     = waddr_ff;
      nm_wdata     = msg_rdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               case (req_data.func)
                  FUNC_WRITE: begin
                     msg_we   = ({1'b0, req_data.msg_addr} < MSG_DEPTH_LEN);
                     state_in = ST_DONE;
                  end
                  FUNC_PARSE: begin
                     pos_in   = POS_W'(req_data.start_offset);
                     mlen_in  = (req_data.msg_length > MSG_DEPTH_LEN) ?
                                MSG_DEPTH_LEN : req_data.msg_length;
                     limit_in = (name_limit_ff > NAME_DEPTH_CNT) ?
                                NAME_DEPTH_CNT : name_limit_ff;
                     count_in = '0;
                     took_in  = 1'b0;
                     jumps_in = '0;
                     res_in.status = 1'b1;
                     state_in = ST_FETCH;
                  end
                  FUNC_READ: begin
                     idx_ok_in = ({1'b0, req_data.name_index} < NAME_DEPTH_CNT);
                     state_in  = ST_NREAD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_NREAD: begin
            res_in.name_char = idx_ok_ff ? nm_rdata : 8'h00;
            state_in         = ST_DONE;
         end
         ST_FETCH: begin
            if (pos_ff >= POS_W'(mlen_ff)) begin
               res_in.status      = 1'b0;
               res_in.next_offset = ok_offset;
               res_in.name_length = count_ff;
               state_in           = ST_DONE;
            end else begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            msg_raddr = pos_inc1[MSG_AW-1:0];
            if (msg_rdata == 8'h00) begin
               pos_in             = pos_inc1[POS_W-1:0];
               res_in.status      = 1'b0;
               res_in.next_offset = ok_offset_zero;
               res_in.name_length = count_ff;
               state_in           = ST_DONE;
            end else if (msg_rdata[7:6] == PTR_MARK) begin
               if (!took_ff) begin
                  resume_in = pos_ff[LEN_W-1:0] + LEN_W'(2);
                  took_in   = 1'b1;
               end
               if ((jumps_ff == MAX_JUMPS_CNT) || (pos_inc1 >= (POS_W+1)'(mlen_ff))) begin
                  state_in = ST_DONE;
               end else begin
                  jumps_in = jumps_ff + JUMP_W'(1);
                  hi_in    = msg_rdata[5:0];
                  state_in = ST_PTRLO;
               end
            end else if (lab_end > (POS_W+1)'(mlen_ff)) begin
               state_in = ST_DONE;
            end else begin
               pos_in = pos_inc1[POS_W-1:0];
               lab_in = msg_rdata;
               if ((count_ff != '0) && (count_ff < limit_ff)) begin
                  nm_we    = 1'b1;
                  nm_waddr = count_ff[NAME_AW-1:0];
                  nm_wdata = DOT_CHAR;
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_COPY;
            end
         end
         ST_PTRLO: begin
            pos_in   = {hi_ff, msg_rdata};
            state_in = ST_FETCH;
         end
         ST_COPY: begin
            if (lab_ff == 8'h00) begin
               state_in = ST_FETCH;
            end else if (count_ff >= limit_ff) begin
               pos_in   = pos_ff + POS_W'(lab_ff);
               lab_in   = 8'h00;
               state_in = ST_FETCH;
            end else begin
               pos_in   = pos_inc1[POS_W-1:0];
               lab_in   = lab_ff - 8'd1;
               wpend_in = 1'b1;
               waddr_in = count_ff[NAME_AW-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wpend_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         name_limit_ff <= NAME_LIMIT_RST;
      end else begin
         state_ff      <= state_in;
         wpend_ff      <= wpend_in;
         rsp_valid_ff  <= rsp_valid_in;
         name_limit_ff <= name_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      mlen_ff     <= mlen_in;
      limit_ff    <= limit_in;
      count_ff    <= count_in;
      resume_ff   <= resume_in;
      took_ff     <= took_in;
      jumps_ff    <= jumps_in;
      lab_ff      <= lab_in;
      hi_ff       <= hi_in;
      waddr_ff    <= waddr_in;
      idx_ok_ff   <= idx_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   dnsd_ram #(
      .WIDTH (8),
      .DEPTH (MSG_DEPTH)
   ) u_msg_ram (
      .clock (clock),
      .we    (msg_we),
      .waddr (req_data.msg_addr[MSG_AW-1:0]),
      .wdata (req_data.msg_byte),
      .raddr (msg_raddr),
      .rdata (msg_rdata)
   );

   dnsd_ram #(
      .WIDTH (8),
      .DEPTH (NAME_DEPTH)
   ) u_name_ram (
      .clock (clock),
      .we    (nm_we),
      .waddr (nm_waddr),
      .wdata (nm_wdata),
      .raddr (req_data.name_index[NAME_AW-1:0]),
      .rdata (nm_rdata)
   );

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE) |-> !wpend_ff)
      else $error("pending name write collides with dot write");

   a_name_in_limit: assert property (@(posedge clock) disable iff (reset)
      nm_we |-> ({1'b0, nm_waddr} < limit_ff))
      else $error("name store written at or past the limit");

   a_jumps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_DECODE || state_ff == ST_PTRLO ||
       state_ff == ST_COPY) |-> (jumps_ff <= MAX_JUMPS_CNT))
      else $error("jump count exceeds bound");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |->
         (rsp_data_ff.next_offset == '0 && rsp_data_ff.name_length == '0 &&
          rsp_data_ff.name_char == '0))
      else $error("error result carries nonzero fields");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

endmodule

`default_nettype wire

### hdl/dnsd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dnsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
